// ===== hdl/see_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package see_pkg;

  typedef struct packed {
    logic [63:0] program_req;
    logic signed [63:0] arg_a;
    logic signed [63:0] arg_b;
    logic signed [63:0] arg_c;
    logic signed [63:0] arg_d;
  } see_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0] status;
    logic saturated;
  } see_out_t;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StUnderflow = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;
  localparam logic [1:0] StDepth = 2'd3;

  localparam logic [3:0] OpArgA = 4'd6;
  localparam logic [3:0] OpArgB = 4'd7;
  localparam logic [3:0] OpArgC = 4'd8;
  localparam logic [3:0] OpArgD = 4'd9;
  localparam logic [3:0] OpAdd = 4'd10;
  localparam logic [3:0] OpSub = 4'd11;
  localparam logic [3:0] OpMul = 4'd12;
  localparam logic [3:0] OpDiv = 4'd13;
  localparam logic [3:0] OpSqr = 4'd14;
  localparam logic [3:0] OpNop = 4'd15;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

endpackage
`default_nettype wire

// ===== hdl/see_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one stack entry; shifts toward its neighbors on push and pop
module see_cell (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        clear_i,
  input  wire logic        push_i,
  input  wire logic        pop_i,
  input  wire logic        wr_top_i,
  input  wire logic        is_top_i,
  input  wire logic [63:0] top_val_i,
  input  wire logic [63:0] up_i,
  input  wire logic [63:0] down_i,
  output logic      [63:0] val_o,
  output logic             valid_o
);
  logic [63:0] val_q, val_d;
  logic valid_q, valid_d;
  logic up_valid;

  // cell 0 holds the top; push shifts down, pop shifts up
  assign up_valid = 1'b0;
  always_comb begin
    val_d = val_q;
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = up_valid;
    end else if (push_i) begin
      val_d = up_i;
      valid_d = 1'b1;
    end else if (pop_i) begin
      val_d = down_i;
    end
    if (wr_top_i && is_top_i) begin
      val_d = top_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign valid_o = valid_q;
endmodule
`default_nettype wire

// ===== hdl/see_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// multi-cycle arithmetic unit: add, sub, multiply in 4 partial products, restoring divide
module see_alu #(
  parameter int unsigned FracBits = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [3:0]  op_i,
  input  wire logic [63:0] x_i,
  input  wire logic [63:0] y_i,
  output logic             done_o,
  output logic      [63:0] res_o,
  output logic             sat_o
);
  typedef enum logic [5:0] {
    AIdle = 6'b000001, AMul = 6'b000010, AMulFin = 6'b000100,
    ADiv = 6'b001000, ADivFin = 6'b010000, ADone = 6'b100000
  } alu_e;

  alu_e st_q, st_d;
  logic neg_q, neg_d;
  logic [63:0] xm_q, xm_d, ym_q, ym_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0] pp_q, pp_d;
  logic [6:0] cnt_q, cnt_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [127:0] num_q, num_d;
  logic [63:0] res_q, res_d;
  logic sat_q, sat_d;

  logic [63:0] sum, dif, xmag, ymag, pa, pb;
  logic [31:0] ha, hb;
  logic [63:0] prod;
  logic [127:0] shifted, rq;
  logic [64:0] r2, rsub;
  logic huge;
  logic big;
  logic [64:0] mag65;

  assign sum = x_i + y_i;
  assign dif = x_i - y_i;
  assign xmag = x_i[63] ? (64'd0 - x_i) : x_i;
  assign ymag = y_i[63] ? (64'd0 - y_i) : y_i;
  assign pa = xm_q;
  assign pb = ym_q;
  assign ha = pp_q[0] ? pa[63:32] : pa[31:0];
  assign hb = pp_q[1] ? pb[63:32] : pb[31:0];
  assign prod = {32'd0, ha} * {32'd0, hb};
  assign shifted = acc_q >> FracBits;
  assign rq = (FracBits > 0) ? (shifted + {127'd0, acc_q[(FracBits > 0) ? FracBits - 1 : 0]})
                             : acc_q;
  assign r2 = {rem_q[63:0], num_q[127]};
  assign rsub = r2 - {1'b0, ym_q};

  // clamp helper inputs
  always_comb begin
    huge = 1'b0;
    mag65 = '0;
    if (st_q == AMulFin) begin
      huge = |rq[127:64];
      mag65 = {1'b0, rq[63:0]};
    end else begin
      // divide rounding: rem >= d - rem
      mag65 = {1'b0, quo_q} + {64'd0, (rem_q >= ({1'b0, ym_q} - rem_q))};
      huge = mag65[64];
    end
  end

  // quotient bits above 64 also force a clamp
  assign big = huge | ((st_q == ADivFin) & acc_q[0]);

  always_comb begin
    st_d = st_q; neg_d = neg_q; xm_d = xm_q; ym_d = ym_q; acc_d = acc_q;
    pp_d = pp_q; cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; num_d = num_q;
    res_d = res_q; sat_d = 1'b0;
    unique case (st_q)
      AIdle: begin
        if (start_i) begin
          neg_d = x_i[63] ^ y_i[63];
          xm_d = xmag;
          ym_d = (op_i == see_pkg::OpSqr) ? xmag : ymag;
          if (op_i == see_pkg::OpSqr) neg_d = 1'b0;
          acc_d = '0; pp_d = '0; cnt_d = '0; quo_d = '0;
          num_d = {64'd0, xmag} << FracBits;
          rem_d = '0;
          unique case (op_i)
            see_pkg::OpAdd: begin
              res_d = sum; st_d = ADone;
              if (x_i[63] == y_i[63] && sum[63] != x_i[63]) begin
                sat_d = 1'b1;
                res_d = x_i[63] ? see_pkg::MinNeg : see_pkg::MaxPos;
              end
            end
            see_pkg::OpSub: begin
              res_d = dif; st_d = ADone;
              if (x_i[63] != y_i[63] && dif[63] != x_i[63]) begin
                sat_d = 1'b1;
                res_d = x_i[63] ? see_pkg::MinNeg : see_pkg::MaxPos;
              end
            end
            see_pkg::OpDiv: st_d = ADiv;
            default: st_d = AMul;
          endcase
        end
      end
      AMul: begin
        acc_d = acc_q + ({64'd0, prod} <<
                         ({6'd0, pp_q[0]} * 7'd32 + {6'd0, pp_q[1]} * 7'd32));
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3) st_d = AMulFin;
      end
      ADiv: begin
        // one quotient bit per cycle over 128 numerator bits
        num_d = num_q << 1;
        quo_d = {quo_q[62:0], 1'b0};
        if (!rsub[64]) begin
          rem_d = rsub;
          quo_d[0] = 1'b1;
        end else begin
          rem_d = r2;
        end
        if (cnt_q < 7'd64 && !rsub[64]) begin
          // quotient bit above 64: overflow marker kept in acc bit 0
          acc_d[0] = 1'b1;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) st_d = ADivFin;
      end
      AMulFin, ADivFin: begin
        st_d = ADone;
        if (neg_q) begin
          if (big || mag65[63:0] > see_pkg::MinNeg) begin
            sat_d = 1'b1; res_d = see_pkg::MinNeg;
          end else res_d = 64'd0 - mag65[63:0];
        end else begin
          if (big || mag65[63:0] > see_pkg::MaxPos) begin
            sat_d = 1'b1; res_d = see_pkg::MaxPos;
          end else res_d = mag65[63:0];
        end
      end
      ADone: st_d = AIdle;
      default: st_d = AIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AIdle;
      sat_q <= 1'b0;
    end else begin
      st_q <= st_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; xm_q <= xm_d; ym_q <= ym_d; acc_q <= acc_d; pp_q <= pp_d;
    cnt_q <= cnt_d; rem_q <= rem_d; quo_q <= quo_d; num_q <= num_d; res_q <= res_d;
  end

  assign done_o = (st_q == ADone);
  assign res_o = res_q;
  assign sat_o = sat_q;
endmodule
`default_nettype wire

// ===== hdl/stack_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// stack expression evaluator
// start with req_i launches one transaction when busy is low. the program
// is stepped one opcode per cycle from the low nibble, held while the alu
// works; the stack is a chain of cells that shift down on push and up on
// pop. a push or nop is done by the sequencer alone, add, subtract,
// multiply, square and divide wait for the alu, and divide takes one quotient
// bit a cycle in a restoring divider. after the last slot the SStep state
// checks the depth and SOut registers the result; an error ends the
// program early. one transaction is in flight at a time, and start is
// taken again in the cycle that done_o is high.
// the result appears on rsp_o with done_o, which is high for one cycle, and
// cannot be stalled; rsp_o holds it until the next result. reset clears the
// sequencer and cell valid bits; no transaction is lost at reset other than the one in flight.
module stack_expression_evaluator #(
  parameter int unsigned PROGRAM_SLOTS = 16,
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  see_pkg::see_in_t     req_i,
  output logic                 done_o,
  output see_pkg::see_out_t    rsp_o
);
  localparam int unsigned SlotW = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;

  typedef enum logic [3:0] {
    SIdle = 4'b0001, SStep = 4'b0010, SAlu = 4'b0100, SOut = 4'b1000
  } st_e;

  st_e st_q, st_d;
  see_pkg::see_in_t in_q;
  logic [SlotW:0] slot_q, slot_d;
  logic [4:0] depth_q, depth_d;
  logic [1:0] stat_q, stat_d;
  logic sat_q, sat_d;
  logic [3:0] op;
  logic [63:0] pushv;
  logic push, pop, wr_top, clear;
  logic [63:0] cval [STACK_DEPTH+1];
  logic [STACK_DEPTH-1:0] cvalid;
  logic alu_start, alu_done, alu_sat;
  logic [63:0] alu_res;
  logic [3:0] alu_op_q, alu_op_d;
  logic [63:0] top_val;

  assign op = in_q.program_req[{slot_q[SlotW-1:0], 2'b00} +: 4];

  always_comb begin
    unique case (op)
      see_pkg::OpArgA: pushv = in_q.arg_a;
      see_pkg::OpArgB: pushv = in_q.arg_b;
      see_pkg::OpArgC: pushv = in_q.arg_c;
      see_pkg::OpArgD: pushv = in_q.arg_d;
      default: pushv = {60'd0, op} << FRACTION_BITS;
    endcase
  end

  // sequencer
  always_comb begin
    st_d = st_q; slot_d = slot_q; depth_d = depth_q; stat_d = stat_q; sat_d = sat_q;
    push = 1'b0; pop = 1'b0; wr_top = 1'b0; clear = 1'b0; alu_start = 1'b0;
    alu_op_d = alu_op_q; top_val = alu_res;
    unique case (st_q)
      SIdle: begin
        if (start) begin
          st_d = SStep; slot_d = '0; depth_d = '0; stat_d = see_pkg::StOk;
          sat_d = 1'b0; clear = 1'b1;
        end
      end
      SStep: begin
        if (slot_q == (SlotW+1)'(PROGRAM_SLOTS)) begin
          if (depth_q != 5'd1) stat_d = see_pkg::StDepth;
          st_d = SOut;
        end else begin
          slot_d = slot_q + 1'b1;
          if (op < see_pkg::OpAdd) begin
            if (depth_q >= 5'(STACK_DEPTH)) begin
              stat_d = see_pkg::StDepth; st_d = SOut;
            end else begin
              push = 1'b1; depth_d = depth_q + 5'd1;
            end
          end else if (op == see_pkg::OpSqr) begin
            if (depth_q < 5'd1) begin
              stat_d = see_pkg::StUnderflow; st_d = SOut;
            end else begin
              alu_start = 1'b1; alu_op_d = op; st_d = SAlu;
            end
          end else if (op != see_pkg::OpNop) begin
            if (depth_q < 5'd2) begin
              stat_d = see_pkg::StUnderflow; st_d = SOut;
            end else if (op == see_pkg::OpDiv && cval[0] == 64'd0) begin
              stat_d = see_pkg::StDivZero; st_d = SOut;
            end else begin
              alu_start = 1'b1; alu_op_d = op; st_d = SAlu;
            end
          end
        end
      end
      SAlu: begin
        if (alu_done) begin
          sat_d = sat_q | alu_sat;
          if (alu_op_q == see_pkg::OpSqr) begin
            wr_top = 1'b1;
          end else begin
            pop = 1'b1; wr_top = 1'b1; depth_d = depth_q - 5'd1;
          end
          st_d = SStep;
        end
      end
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign cval[STACK_DEPTH] = 64'd0;

  // chain of stack cells, cell 0 is the top
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [63:0] up;
    if (g == 0) begin : g_top
      assign up = pushv;
    end else begin : g_mid
      assign up = cval[g-1];
    end
    see_cell u_cell (
      .clk_i, .rst_ni, .clear_i(clear), .push_i(push), .pop_i(pop),
      .wr_top_i(wr_top), .is_top_i(g == 0), .top_val_i(top_val),
      .up_i(up), .down_i(cval[g+1]), .val_o(cval[g]), .valid_o(cvalid[g])
    );
  end

  // pop moves x into the top, and the alu result overrides it
  see_alu #(.FracBits(FRACTION_BITS)) u_alu (
    .clk_i, .rst_ni, .start_i(alu_start), .op_i(op),
    .x_i((op == see_pkg::OpSqr) ? cval[0] : cval[1]), .y_i(cval[0]),
    .done_o(alu_done), .res_o(alu_res), .sat_o(alu_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; done_o <= 1'b0; depth_q <= '0;
    end else begin
      st_q <= st_d; done_o <= (st_q == SOut); depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && start) in_q <= req_i;
    slot_q <= slot_d; stat_q <= stat_d; sat_q <= sat_d;
    alu_op_q <= alu_op_d;
    if (st_q == SOut) begin
      rsp_o.status <= stat_q;
      rsp_o.value <= (stat_q == see_pkg::StOk) ? cval[0] : 64'd0;
      rsp_o.saturated <= (stat_q == see_pkg::StOk) && sat_q;
    end
  end

  assign busy = (st_q != SIdle);

  logic unused_v;
  assign unused_v = ^cvalid;

`ifndef SYNTH
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 5'(STACK_DEPTH)) else $error("depth out of range");
`endif
endmodule
`default_nettype wire
